// ===== rtl/assert_macros.svh =====
// assertion macros shared by the frame ring space manager
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define FRSM_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("frsm assertion failed");

// next-cycle implication, disabled during reset
`define FRSM_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("frsm assertion failed");

`endif

// ===== rtl/frsm_pkg.sv =====
// package: constants, codes and shared types of the frame ring space manager
`timescale 1ns / 1ps
package frsm_pkg;
   localparam int ENTRIES   = 1024;
   localparam int ENTRY_W   = 10;
   localparam int COUNT_W   = 11;
   localparam int BYTE_W    = 20;
   localparam int TIME_W    = 32;
   localparam int KIND_W    = 8;
   localparam int PTS_W     = 32;
   localparam int TMO_W     = 8;
   localparam int STATUS_W  = 2;
   localparam int CSR_IDX_W = 1;
   localparam logic [BYTE_W-1:0] MAX_BYTES   = BYTE_W'(524288);
   localparam logic [BYTE_W-1:0] CAP_RESET   = BYTE_W'(524288);
   localparam logic [TMO_W-1:0]  TMO_RESET   = TMO_W'(3);

   localparam logic FUNC_WRITE = 1'b0;
   localparam logic FUNC_READ  = 1'b1;

   localparam logic [STATUS_W-1:0] STATUS_WRITTEN  = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_READ     = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_REJECTED = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_CAPACITY = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_TIMEOUT  = 1'b1;

   localparam logic [1:0] RD_SEL_A   = 2'd0;
   localparam logic [1:0] RD_SEL_B   = 2'd1;
   localparam logic [1:0] RD_SEL_OLD = 2'd2;

   typedef struct packed {
      logic [PTS_W-1:0]  pts;
      logic [KIND_W-1:0] kind;
      logic [TIME_W-1:0] stamp;
      logic [BYTE_W-1:0] offset;
      logic [BYTE_W-1:0] length;
   } entry_word_type;

   typedef struct packed {
      logic       clear_wr;
      logic       load_req;
      logic [1:0] rd_sel;
      logic       hold_a;
      logic       res_read;
      logic       res_reject;
      logic       wrap_start;
      logic       ev_update;
      logic       commit;
      logic       out_load;
   } ctl_cmd_type;

   typedef struct packed {
      logic clear_last;
      logic func;
      logic too_long;
      logic fits;
      logic full;
      logic need_evict;
   } ctl_sts_type;
endpackage

// ===== rtl/frsm_if.sv =====
// channel interfaces: request and response beats
`timescale 1ns / 1ps
interface frsm_req_if;
   logic                               valid;
   logic                               ready;
   logic                               func;
   logic [frsm_pkg::BYTE_W-1:0]        length;
   logic [frsm_pkg::TIME_W-1:0]        timestamp;
   logic [frsm_pkg::KIND_W-1:0]        frame_type;
   logic [frsm_pkg::PTS_W-1:0]         pts;
   logic [frsm_pkg::ENTRY_W-1:0]       entry_index;
   logic [frsm_pkg::ENTRY_W-1:0]       compare_index;
   modport source (output valid, func, length, timestamp, frame_type, pts, entry_index,
                   compare_index, input ready);
   modport sink (input valid, func, length, timestamp, frame_type, pts, entry_index,
                 compare_index, output ready);
endinterface

interface frsm_rsp_if;
   logic                               valid;
   logic                               ready;
   logic [frsm_pkg::STATUS_W-1:0]      status;
   logic [frsm_pkg::BYTE_W-1:0]        offset;
   logic [frsm_pkg::ENTRY_W-1:0]       written_index;
   logic [frsm_pkg::BYTE_W-1:0]        entry_length;
   logic [frsm_pkg::KIND_W-1:0]        entry_type;
   logic [frsm_pkg::PTS_W-1:0]         entry_pts;
   logic                               timed_out;
   logic [frsm_pkg::COUNT_W-1:0]       evicted_count;
   modport source (output valid, status, offset, written_index, entry_length, entry_type,
                   entry_pts, timed_out, evicted_count, input ready);
   modport sink (input valid, status, offset, written_index, entry_length, entry_type,
                 entry_pts, timed_out, evicted_count, output ready);
endinterface

// ===== rtl/frsm_ctrl.sv =====
// controller: sequencing of clear pass, reads, eviction walk and commit
`timescale 1ns / 1ps
module frsm_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   input  frsm_pkg::ctl_sts_type  sts,
   output frsm_pkg::ctl_cmd_type  cmd
);
   localparam logic [2:0] ST_CLEAR  = 3'd0;
   localparam logic [2:0] ST_IDLE   = 3'd1;
   localparam logic [2:0] ST_DECODE = 3'd2;
   localparam logic [2:0] ST_RD_B   = 3'd3;
   localparam logic [2:0] ST_RD_CMP = 3'd4;
   localparam logic [2:0] ST_EV_TST = 3'd5;
   localparam logic [2:0] ST_EV_UPD = 3'd6;
   localparam logic [2:0] ST_COMMIT = 3'd7;
   localparam logic [3:0] ST_OUT    = 4'd8;

   logic [3:0] state_ff, state_in;
   logic       valid_ff, valid_in;

   always_comb begin
      state_in  = state_ff;
      valid_in  = valid_ff;
      cmd       = '0;
      cmd.rd_sel = frsm_pkg::RD_SEL_A;
      req_ready = 1'b0;
      if (valid_ff && rsp_ready) begin
         valid_in = 1'b0;
      end
      case (state_ff)
         {1'b0, ST_CLEAR}: begin
            cmd.clear_wr = 1'b1;
            if (sts.clear_last) begin
               state_in = {1'b0, ST_IDLE};
            end
         end
         {1'b0, ST_IDLE}: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load_req = 1'b1;
               state_in = {1'b0, ST_DECODE};
            end
         end
         {1'b0, ST_DECODE}: begin
            if (sts.func == frsm_pkg::FUNC_READ) begin
               cmd.rd_sel = frsm_pkg::RD_SEL_A;
               state_in = {1'b0, ST_RD_B};
            end else if (sts.too_long) begin
               cmd.res_reject = 1'b1;
               state_in = ST_OUT;
            end else if (!sts.fits) begin
               cmd.wrap_start = 1'b1;
               state_in = {1'b0, ST_EV_TST};
            end else if (sts.full) begin
               state_in = {1'b0, ST_EV_TST};
            end else begin
               state_in = {1'b0, ST_COMMIT};
            end
         end
         {1'b0, ST_RD_B}: begin
            cmd.rd_sel = frsm_pkg::RD_SEL_B;
            cmd.hold_a = 1'b1;
            state_in = {1'b0, ST_RD_CMP};
         end
         {1'b0, ST_RD_CMP}: begin
            cmd.res_read = 1'b1;
            state_in = ST_OUT;
         end
         {1'b0, ST_EV_TST}: begin
            if (sts.need_evict) begin
               cmd.rd_sel = frsm_pkg::RD_SEL_OLD;
               state_in = {1'b0, ST_EV_UPD};
            end else begin
               state_in = {1'b0, ST_COMMIT};
            end
         end
         {1'b0, ST_EV_UPD}: begin
            cmd.ev_update = 1'b1;
            state_in = {1'b0, ST_EV_TST};
         end
         {1'b0, ST_COMMIT}: begin
            cmd.commit = 1'b1;
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (!valid_ff || rsp_ready) begin
               cmd.out_load = 1'b1;
               valid_in = 1'b1;
               state_in = {1'b0, ST_IDLE};
            end
         end
         default: begin
            state_in = {1'b0, ST_IDLE};
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= {1'b0, ST_CLEAR};
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
   end

   assign rsp_valid = valid_ff;
endmodule

// ===== rtl/frsm_dp.sv =====
// datapath: descriptor memory, space accounting, config registers, result beat
`timescale 1ns / 1ps
module frsm_dp (
   input  logic                   clock,
   input  logic                   reset,
   input  frsm_pkg::ctl_cmd_type  cmd,
   output frsm_pkg::ctl_sts_type  sts,
   input  logic                                  csr_we,
   input  logic [frsm_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [frsm_pkg::BYTE_W-1:0]           csr_wdata,
   frsm_req_if.sink   req_chan,
   frsm_rsp_if.source rsp_chan
);
   localparam int BW = frsm_pkg::BYTE_W;
   localparam int EW = frsm_pkg::ENTRY_W;
   localparam int CW = frsm_pkg::COUNT_W;
   localparam int TW = frsm_pkg::TIME_W;

   frsm_pkg::entry_word_type mem_ff [frsm_pkg::ENTRIES];
   frsm_pkg::entry_word_type rd_ff, hold_ff, wr_data;
   logic [EW-1:0]            rd_addr, wr_addr;
   logic                     wr_en;

   logic [BW-1:0] cap_ff, wpos_ff, wpos_in, free_ff, free_in;
   logic [frsm_pkg::TMO_W-1:0] tmo_ff;
   logic [EW-1:0] next_ff, next_in, old_ff, old_in, whead_ff, whead_in, clr_ff;
   logic          full_ff, full_in;
   logic [CW-1:0] evn_ff, evn_in;

   logic                        func_ff;
   logic [BW-1:0]               len_ff;
   logic [TW-1:0]               stamp_ff;
   logic [frsm_pkg::KIND_W-1:0] kind_ff;
   logic [frsm_pkg::PTS_W-1:0]  pts_ff;
   logic [EW-1:0]               ia_ff, ib_ff;

   logic [frsm_pkg::STATUS_W-1:0] res_status_ff, out_status_ff;
   logic [BW-1:0]                 res_offset_ff, out_offset_ff, res_len_ff, out_len_ff;
   logic [EW-1:0]                 res_index_ff, out_index_ff;
   logic [frsm_pkg::KIND_W-1:0]   res_kind_ff, out_kind_ff;
   logic [frsm_pkg::PTS_W-1:0]    res_pts_ff, out_pts_ff;
   logic                          res_to_ff, out_to_ff;
   logic [CW-1:0]                 res_ev_ff, out_ev_ff;

   logic [BW-1:0] cap_eff, free_min, room, credit, ev_free;
   logic [EW-1:0] old_succ;
   logic [BW:0]   wpos_sum;
   logic [TW:0]   lhs;

   // effective capacity and space checks
   always_comb begin
      if (cap_ff == '0) begin
         cap_eff = BW'(1);
      end else if (cap_ff > frsm_pkg::MAX_BYTES) begin
         cap_eff = frsm_pkg::MAX_BYTES;
      end else begin
         cap_eff = cap_ff;
      end
      wpos_sum = {1'b0, wpos_ff} + {1'b0, len_ff};
      old_succ = old_ff + EW'(1);
      if (whead_ff == old_succ) begin
         credit = (rd_ff.offset < cap_eff) ? cap_eff - rd_ff.offset : '0;
      end else begin
         credit = rd_ff.length;
      end
      free_min = (free_ff < cap_eff) ? free_ff : cap_eff;
      room     = cap_eff - free_min;
      ev_free  = (credit >= room) ? cap_eff : free_ff + credit;
      lhs      = {1'b0, hold_ff.stamp} + {{(TW+1-frsm_pkg::TMO_W){1'b0}}, tmo_ff};
   end

   assign sts.clear_last = (clr_ff == EW'(frsm_pkg::ENTRIES - 1));
   assign sts.func       = func_ff;
   assign sts.too_long   = (len_ff > cap_eff);
   assign sts.fits       = (wpos_sum <= {1'b0, cap_eff});
   assign sts.full       = full_ff;
   assign sts.need_evict = (free_ff < len_ff) && (evn_ff < CW'(frsm_pkg::ENTRIES));

   // memory ports
   always_comb begin
      case (cmd.rd_sel)
         frsm_pkg::RD_SEL_A:   rd_addr = ia_ff;
         frsm_pkg::RD_SEL_B:   rd_addr = ib_ff;
         frsm_pkg::RD_SEL_OLD: rd_addr = old_ff;
         default:              rd_addr = ia_ff;
      endcase
      wr_en   = cmd.clear_wr || cmd.ev_update || cmd.commit;
      wr_data = '0;
      if (cmd.clear_wr) begin
         wr_addr = clr_ff;
      end else if (cmd.ev_update) begin
         wr_addr = old_ff;
      end else begin
         wr_addr        = next_ff;
         wr_data.length = len_ff;
         wr_data.offset = wpos_ff;
         wr_data.stamp  = stamp_ff;
         wr_data.kind   = kind_ff;
         wr_data.pts    = pts_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_ff <= mem_ff[rd_addr];
   end

   // ring and space state
   always_comb begin
      wpos_in  = wpos_ff;
      free_in  = free_ff;
      next_in  = next_ff;
      old_in   = old_ff;
      whead_in = whead_ff;
      full_in  = full_ff;
      evn_in   = evn_ff;
      if (cmd.load_req) begin
         evn_in = '0;
      end
      if (cmd.wrap_start) begin
         old_in   = whead_ff;
         whead_in = next_ff;
         free_in  = '0;
         wpos_in  = '0;
         full_in  = 1'b1;
      end
      if (cmd.ev_update) begin
         old_in  = old_succ;
         free_in = ev_free;
         evn_in  = evn_ff + CW'(1);
      end
      if (cmd.commit) begin
         free_in = (free_ff >= len_ff) ? free_ff - len_ff : '0;
         wpos_in = wpos_sum[BW-1:0];
         next_in = next_ff + EW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff   <= frsm_pkg::CAP_RESET;
         tmo_ff   <= frsm_pkg::TMO_RESET;
         wpos_ff  <= '0;
         free_ff  <= frsm_pkg::CAP_RESET;
         next_ff  <= '0;
         old_ff   <= '0;
         whead_ff <= '0;
         full_ff  <= 1'b0;
         evn_ff   <= '0;
         clr_ff   <= '0;
      end else begin
         if (csr_we && csr_index == frsm_pkg::CSR_CAPACITY) begin
            cap_ff <= csr_wdata;
         end
         if (csr_we && csr_index == frsm_pkg::CSR_TIMEOUT) begin
            tmo_ff <= csr_wdata[frsm_pkg::TMO_W-1:0];
         end
         wpos_ff  <= wpos_in;
         free_ff  <= free_in;
         next_ff  <= next_in;
         old_ff   <= old_in;
         whead_ff <= whead_in;
         full_ff  <= full_in;
         evn_ff   <= evn_in;
         if (cmd.clear_wr) begin
            clr_ff <= clr_ff + EW'(1);
         end
      end
   end

   // request capture, result staging and output beat
   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         func_ff  <= req_chan.func;
         len_ff   <= req_chan.length;
         stamp_ff <= req_chan.timestamp;
         kind_ff  <= req_chan.frame_type;
         pts_ff   <= req_chan.pts;
         ia_ff    <= req_chan.entry_index;
         ib_ff    <= req_chan.compare_index;
      end
      if (cmd.hold_a) begin
         hold_ff <= rd_ff;
      end
      if (cmd.res_reject || cmd.res_read || cmd.commit) begin
         res_status_ff <= frsm_pkg::STATUS_REJECTED;
         res_offset_ff <= '0;
         res_index_ff  <= '0;
         res_len_ff    <= '0;
         res_kind_ff   <= '0;
         res_pts_ff    <= '0;
         res_to_ff     <= 1'b0;
         res_ev_ff     <= '0;
         if (cmd.res_read) begin
            res_status_ff <= frsm_pkg::STATUS_READ;
            res_offset_ff <= hold_ff.offset;
            res_len_ff    <= hold_ff.length;
            res_kind_ff   <= hold_ff.kind;
            res_pts_ff    <= hold_ff.pts;
            res_to_ff     <= (lhs <= {1'b0, rd_ff.stamp});
         end
         if (cmd.commit) begin
            res_status_ff <= frsm_pkg::STATUS_WRITTEN;
            res_offset_ff <= wpos_ff;
            res_index_ff  <= next_ff;
            res_ev_ff     <= evn_ff;
         end
      end
      if (cmd.out_load) begin
         out_status_ff <= res_status_ff;
         out_offset_ff <= res_offset_ff;
         out_index_ff  <= res_index_ff;
         out_len_ff    <= res_len_ff;
         out_kind_ff   <= res_kind_ff;
         out_pts_ff    <= res_pts_ff;
         out_to_ff     <= res_to_ff;
         out_ev_ff     <= res_ev_ff;
      end
   end

   assign rsp_chan.status        = out_status_ff;
   assign rsp_chan.offset        = out_offset_ff;
   assign rsp_chan.written_index = out_index_ff;
   assign rsp_chan.entry_length  = out_len_ff;
   assign rsp_chan.entry_type    = out_kind_ff;
   assign rsp_chan.entry_pts     = out_pts_ff;
   assign rsp_chan.timed_out     = out_to_ff;
   assign rsp_chan.evicted_count = out_ev_ff;
endmodule

// ===== rtl/frame_ring_space_manager_top.sv =====
// top level: frame ring space manager, controller plus datapath
//
//   channel   dir   handshake          carries
//   req_chan  in    valid/ready        func, length, timestamp, frame_type, pts, indices
//   rsp_chan  out   valid/ready        status, offset, index, stored descriptor, flags
//   csr_*     in    csr_we only        capacity (index 0), timeout (index 1)
//
// after reset a clear pass zeroes the whole descriptor memory; no beat is taken meanwhile
// read: DECODE reads entry A, RD_B holds it and reads entry B, RD_CMP fills the result register
// write: DECODE then COMMIT when not full; when full or wrapping, EV_TST and EV_UPD per evicted entry first
// rejected write: DECODE goes straight to OUT
// one item in flight; the next is taken while the previous result waits on rsp_chan
`timescale 1ns / 1ps
`include "assert_macros.svh"
module frame_ring_space_manager_top (
   input  logic                               clock,
   input  logic                               reset,
   frsm_req_if.sink                           req_chan,
   frsm_rsp_if.source                         rsp_chan,
   input  logic                               csr_we,
   input  logic [frsm_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [frsm_pkg::BYTE_W-1:0]        csr_wdata
);
   frsm_pkg::ctl_cmd_type cmd;
   frsm_pkg::ctl_sts_type sts;

   frsm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   frsm_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .sts       (sts),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan)
   );

   `FRSM_ASSERT_NEXT(a_one_in_flight, clock, reset, req_chan.valid && req_chan.ready, !req_chan.ready)
   `FRSM_ASSERT_NOW(a_no_beat_in_clear, clock, reset, cmd.clear_wr, !req_chan.ready)
   `FRSM_ASSERT_NOW(a_evict_when_full, clock, reset, cmd.ev_update, sts.full)
   `FRSM_ASSERT_NOW(a_commit_fits, clock, reset, cmd.commit, !sts.too_long)
endmodule

// ===== dv/frame_ring_space_manager_top_tb.sv =====
// testbench: frame ring space manager, directed table then random phases checked by a predictor
`timescale 1ns / 1ps
module frame_ring_space_manager_top_tb;
   localparam int BW = frsm_pkg::BYTE_W;
   localparam int EW = frsm_pkg::ENTRY_W;
   localparam int CW = frsm_pkg::COUNT_W;
   localparam int KW = frsm_pkg::KIND_W;

   typedef struct packed {
      logic                        func;
      logic [BW-1:0]               length;
      logic [frsm_pkg::TIME_W-1:0] timestamp;
      logic [KW-1:0]               frame_type;
      logic [frsm_pkg::PTS_W-1:0]  pts;
      logic [EW-1:0]               entry_index;
      logic [EW-1:0]               compare_index;
   } frame_req_type;

   typedef struct packed {
      logic [frsm_pkg::STATUS_W-1:0] status;
      logic [BW-1:0]                 offset;
      logic [EW-1:0]                 written_index;
      logic [BW-1:0]                 entry_length;
      logic [KW-1:0]                 entry_type;
      logic [frsm_pkg::PTS_W-1:0]    entry_pts;
      logic                          timed_out;
      logic [CW-1:0]                 evicted_count;
   } frame_rsp_type;

   typedef struct packed {
      frame_req_type req;
      logic          typed;
      frame_rsp_type rsp;
   } stim_row_type;

   localparam int STALL_LIMIT = 20000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_we = 1'b0;
   logic [frsm_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [BW-1:0] csr_wdata = '0;

   frsm_req_if req_chan ();
   frsm_rsp_if rsp_chan ();

   frame_ring_space_manager_top DUT (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #10 clock = ~clock;

   // descriptor ring and space bookkeeping
   logic [BW-1:0]               ring_len [frsm_pkg::ENTRIES];
   logic [BW-1:0]               ring_off [frsm_pkg::ENTRIES];
   logic [frsm_pkg::TIME_W-1:0] ring_time [frsm_pkg::ENTRIES];
   logic [KW-1:0]               ring_kind [frsm_pkg::ENTRIES];
   logic [frsm_pkg::PTS_W-1:0]  ring_pts [frsm_pkg::ENTRIES];
   int unsigned   wr_pos, free_bytes;
   logic [EW-1:0] next_slot, oldest_slot, wrap_head;
   bit            ring_full;
   int unsigned   cap_reg, tmo_reg;

   frame_rsp_type pending_rsp [$];
   int            errors = 0;
   bit            quiet = 1'b0;
   int unsigned   ts_base = 0;

   function automatic int unsigned usable_cap();
      if (cap_reg == 0) return 1;
      if (cap_reg > frsm_pkg::MAX_BYTES) return frsm_pkg::MAX_BYTES;
      return cap_reg;
   endfunction

   function automatic int unsigned evict_oldest(int unsigned len, int unsigned cap);
      int unsigned   n, credit, held;
      logic [EW-1:0] victim;
      n = 0;
      while (free_bytes < len && n < frsm_pkg::ENTRIES) begin
         victim = oldest_slot;
         oldest_slot = victim + EW'(1);
         if (wrap_head == oldest_slot)
            credit = (ring_off[victim] < cap) ? cap - ring_off[victim] : 0;
         else
            credit = ring_len[victim];
         held = (free_bytes < cap) ? free_bytes : cap;
         free_bytes = (credit >= cap - held) ? cap : free_bytes + credit;
         ring_len[victim] = '0;
         ring_off[victim] = '0;
         ring_time[victim] = '0;
         ring_kind[victim] = '0;
         ring_pts[victim] = '0;
         n++;
      end
      return n;
   endfunction

   function automatic frame_rsp_type predict_frame(frame_req_type it);
      frame_rsp_type r;
      int unsigned   len, cap, ev;
      logic [EW-1:0] slot, a, b;
      r = '0;
      if (it.func == frsm_pkg::FUNC_READ) begin
         a = it.entry_index;
         b = it.compare_index;
         r.status = frsm_pkg::STATUS_READ;
         r.offset = ring_off[a];
         r.entry_length = ring_len[a];
         r.entry_type = ring_kind[a];
         r.entry_pts = ring_pts[a];
         r.timed_out = (33'(ring_time[a]) + 33'(tmo_reg)) <= 33'(ring_time[b]);
         return r;
      end
      len = it.length;
      cap = usable_cap();
      ev = 0;
      if (len > cap) begin
         r.status = frsm_pkg::STATUS_REJECTED;
         return r;
      end
      if (wr_pos + len > cap) begin
         oldest_slot = wrap_head;
         wrap_head = next_slot;
         free_bytes = 0;
         wr_pos = 0;
         ev = evict_oldest(len, cap);
         ring_full = 1'b1;
      end else if (ring_full) begin
         ev = evict_oldest(len, cap);
      end
      slot = next_slot;
      ring_len[slot] = BW'(len);
      ring_off[slot] = BW'(wr_pos);
      ring_time[slot] = it.timestamp;
      ring_kind[slot] = it.frame_type;
      ring_pts[slot] = it.pts;
      free_bytes = (free_bytes >= len) ? free_bytes - len : 0;
      r.status = frsm_pkg::STATUS_WRITTEN;
      r.offset = BW'(wr_pos);
      r.written_index = slot;
      r.evicted_count = CW'(ev);
      wr_pos += len;
      next_slot = slot + EW'(1);
      return r;
   endfunction

   function automatic int pick_gap();
      int r;
      if (quiet) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   task automatic send_frame_req(input frame_req_type it, input logic typed,
                                 input frame_rsp_type fixed);
      frame_rsp_type p;
      int g;
      req_chan.valid <= 1'b1;
      req_chan.func <= it.func;
      req_chan.length <= it.length;
      req_chan.timestamp <= it.timestamp;
      req_chan.frame_type <= it.frame_type;
      req_chan.pts <= it.pts;
      req_chan.entry_index <= it.entry_index;
      req_chan.compare_index <= it.compare_index;
      do @(posedge clock); while (!req_chan.ready);
      p = predict_frame(it);
      pending_rsp.push_back(typed ? fixed : p);
      if ($urandom_range(0, 63) == 0) quiet = ~quiet;
      g = pick_gap();
      if (g > 0) begin
         req_chan.valid <= 1'b0;
         repeat (g) @(posedge clock);
      end
   endtask

   task automatic settle();
      req_chan.valid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (16) @(posedge clock);
   endtask

   task automatic csr_write(input logic [frsm_pkg::CSR_IDX_W-1:0] idx,
                            input int unsigned value);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value[BW-1:0];
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == frsm_pkg::CSR_CAPACITY) cap_reg = value & 32'hFFFFF;
      else tmo_reg = value & 32'hFF;
   endtask

   function automatic frame_req_type random_req(int unsigned read_pct, int unsigned max_len);
      frame_req_type it;
      int unsigned   cap, r;
      it = '0;
      cap = usable_cap();
      it.func = ($urandom_range(0, 99) < read_pct) ? frsm_pkg::FUNC_READ : frsm_pkg::FUNC_WRITE;
      r = $urandom_range(0, 99);
      if (r < 5) it.length = BW'($urandom_range(0, frsm_pkg::MAX_BYTES));
      else if (r < 8) it.length = BW'(cap);
      else if (r < 10) it.length = '0;
      else it.length = BW'($urandom_range(0, max_len));
      ts_base += $urandom_range(0, 2);
      it.timestamp = ($urandom_range(0, 19) == 0) ? $urandom() : ts_base;
      it.frame_type = KW'($urandom_range(0, 255));
      it.pts = $urandom();
      if ($urandom_range(0, 1)) begin
         it.entry_index = next_slot - EW'(1) - EW'($urandom_range(0, 8));
         it.compare_index = next_slot - EW'(1);
      end else begin
         it.entry_index = EW'($urandom_range(0, frsm_pkg::ENTRIES - 1));
         it.compare_index = EW'($urandom_range(0, frsm_pkg::ENTRIES - 1));
      end
      return it;
   endfunction

   task automatic run_phase(input int unsigned cap, input int unsigned tmo, input int count,
                            input int unsigned read_pct, input int unsigned max_len);
      settle();
      csr_write(frsm_pkg::CSR_CAPACITY, cap);
      csr_write(frsm_pkg::CSR_TIMEOUT, tmo);
      for (int i = 0; i < count; i++)
         send_frame_req(random_req(read_pct, max_len), 1'b0, '0);
   endtask

   stim_row_type directed [12];

   initial begin
      req_chan.valid = 1'b0;
      req_chan.func = frsm_pkg::FUNC_WRITE;
      req_chan.length = '0;
      req_chan.timestamp = '0;
      req_chan.frame_type = '0;
      req_chan.pts = '0;
      req_chan.entry_index = '0;
      req_chan.compare_index = '0;
      for (int i = 0; i < frsm_pkg::ENTRIES; i++) begin
         ring_len[i] = '0;
         ring_off[i] = '0;
         ring_time[i] = '0;
         ring_kind[i] = '0;
         ring_pts[i] = '0;
      end
      cap_reg = frsm_pkg::CAP_RESET;
      tmo_reg = frsm_pkg::TMO_RESET;
      wr_pos = 0;
      free_bytes = frsm_pkg::CAP_RESET;
      next_slot = '0;
      oldest_slot = '0;
      wrap_head = '0;
      ring_full = 1'b0;

      directed[0] = '{'{frsm_pkg::FUNC_READ, 20'd0, 32'd0, 8'd0, 32'd0, 10'd0, 10'd0}, 1'b1,
                      '{frsm_pkg::STATUS_READ, 20'd0, 10'd0, 20'd0, 8'd0, 32'd0, 1'b0, 11'd0}};
      directed[1] = '{'{frsm_pkg::FUNC_WRITE, 20'd524288, 32'hFFFF_FFFF, 8'hFF, 32'hFFFF_FFFF,
                        10'h3FF, 10'h3FF}, 1'b1,
                      '{frsm_pkg::STATUS_WRITTEN, 20'd0, 10'd0, 20'd0, 8'd0, 32'd0, 1'b0,
                        11'd0}};
      directed[2] = '{'{frsm_pkg::FUNC_WRITE, 20'd0, 32'd0, 8'd0, 32'd0, 10'd0, 10'd0}, 1'b0,
                      '0};
      directed[3] = '{'{frsm_pkg::FUNC_READ, 20'd0, 32'd0, 8'd0, 32'd0, 10'd0, 10'd0}, 1'b0,
                      '0};
      directed[4] = '{'{frsm_pkg::FUNC_READ, 20'd0, 32'd0, 8'd0, 32'd0, 10'h3FF, 10'h3FF},
                      1'b0, '0};
      directed[5] = '{'{frsm_pkg::FUNC_WRITE, 20'd1, 32'd5, 8'h5A, 32'h1234_5678, 10'd0,
                        10'd0}, 1'b0, '0};
      directed[6] = '{'{frsm_pkg::FUNC_WRITE, 20'h7FFFF, 32'd8, 8'hA5, 32'hA5A5_A5A5, 10'd0,
                        10'd0}, 1'b0, '0};
      directed[7] = '{'{frsm_pkg::FUNC_READ, 20'd0, 32'd0, 8'd0, 32'd0, 10'd2, 10'd3}, 1'b0,
                      '0};
      directed[8] = '{'{frsm_pkg::FUNC_READ, 20'd0, 32'd0, 8'd0, 32'd0, 10'd3, 10'd2}, 1'b0,
                      '0};
      directed[9] = '{'{frsm_pkg::FUNC_WRITE, 20'd2, 32'd9, 8'd1, 32'd0, 10'd0, 10'd0}, 1'b0,
                      '0};
      directed[10] = '{'{frsm_pkg::FUNC_READ, 20'd0, 32'd0, 8'd0, 32'd0, 10'd0, 10'd1}, 1'b0,
                       '0};
      directed[11] = '{'{frsm_pkg::FUNC_READ, 20'h8_0000, 32'hFFFF_FFFF, 8'hFF, 32'hFFFF_FFFF,
                         10'd1, 10'd0}, 1'b0, '0};

      repeat (2) @(posedge clock);
      reset <= 1'b0;
      foreach (directed[i])
         send_frame_req(directed[i].req, directed[i].typed, directed[i].rsp);

      run_phase(4096, 3, 200, 30, 1024);
      run_phase(0, 0, 50, 30, 1);
      run_phase(1048575, 255, 60, 30, 65536);
      run_phase(524288, 1, 1050, 3, 1);
      run_phase(300, 2, 40, 25, 64);

      settle();
      if (errors == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

   function automatic void check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
      if (exp_v !== act_v) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
         errors++;
      end
   endfunction

   // result side: random back-pressure and beat checking
   initial begin
      frame_rsp_type e;
      int stall;
      stall = 0;
      rsp_chan.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_chan.valid && rsp_chan.ready) begin
            if (pending_rsp.size() == 0) begin
               $display("%0t: unexpected result beat, expected none, actual status %0h",
                        $time, rsp_chan.status);
               errors++;
            end else begin
               e = pending_rsp.pop_front();
               check_field("status", e.status, rsp_chan.status);
               check_field("offset", e.offset, rsp_chan.offset);
               check_field("written_index", e.written_index, rsp_chan.written_index);
               check_field("entry_length", e.entry_length, rsp_chan.entry_length);
               check_field("entry_type", e.entry_type, rsp_chan.entry_type);
               check_field("entry_pts", e.entry_pts, rsp_chan.entry_pts);
               check_field("timed_out", e.timed_out, rsp_chan.timed_out);
               check_field("evicted_count", e.evicted_count, rsp_chan.evicted_count);
            end
         end
         if (stall > 0) begin
            stall--;
            rsp_chan.ready <= 1'b0;
         end else if (quiet || $urandom_range(0, 99) < 70) begin
            rsp_chan.ready <= 1'b1;
         end else begin
            stall = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 2);
            rsp_chan.ready <= 1'b0;
         end
      end
   end

   int idle_cycles = 0;
   always @(posedge clock) begin
      if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles > STALL_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end
endmodule
